// ===== src/polyline_point_at_length_assert.svh =====
// Assertion macros for the polyline point-at-length block.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef POLYLINE_POINT_AT_LENGTH_ASSERT_SVH
`define POLYLINE_POINT_AT_LENGTH_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define PPAL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds.
`define PPAL_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/ppal_pkg.sv =====
// Shared constants and types for the polyline point-at-length block.
// No dependencies.
package ppal_pkg;

    localparam int MAX_POINTS = 256;
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FEW  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [30:0] LEN_MAX = 31'h7FFF_FFFF;

    // One stored point: coordinates, running length, length of the segment ending here
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [30:0]        cum;
        logic [30:0]        len;
    } entry_t;

    localparam int EW = $bits(entry_t);

endpackage

// ===== src/ppal_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module ppal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                           wdata,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read one entry per cycle and, when we is high, write it; the read returns the old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== src/polyline_point_at_length.sv =====
// Top level of the polyline point-at-length block.
// Depends on ppal_pkg, ppal_ram and polyline_point_at_length_assert.svh.
//
// Usage: drive operation and its operands with start high while busy is low;
// that edge accepts the transaction. Exactly one result comes back per
// transaction: done is high for one cycle with result_x, result_y,
// beyond_end and status valid. The receiver cannot stall; results must be
// taken when done is high.
// Steps: clear, no-op, the first append, a rejected append and a query on
// fewer than two points finish straight from idle. Other appends square the
// two differences on the shared multiplier, run a bit-serial square root
// and then write the point; an append whose squares saturate the length
// skips the square root. A query reads the point memory one stored point
// at a time until the segment is found, then multiplies twice, runs a
// bit-serial divider and takes one final step; a segment of zero length
// returns its start point without the multiply and divide.
// One transaction is in flight at a time; busy is high while it runs.
// Reset clears the point count; the point memory needs no clearing pass.
`include "polyline_point_at_length_assert.svh"

module polyline_point_at_length (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         operation,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] query_length,
    output logic               done,
    output logic signed [31:0] result_x,
    output logic signed [31:0] result_y,
    output logic               beyond_end,
    output logic [1:0]         status
);

    import ppal_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SQX, S_SQY, S_SQRT, S_WRITE,
        S_RD, S_CMP, S_MULX, S_MULY, S_DIV, S_FIN
    } state_t;

    state_t state_reg;

    logic [CW-1:0]      count_reg;
    logic signed [31:0] last_x_reg, last_y_reg;
    logic [30:0]        last_cum_reg;
    logic signed [31:0] px_reg, py_reg, pos_reg;

    logic [32:0]        ax_reg, ay_reg;
    logic [65:0]        sx_reg;
    logic [62:0]        sq_n_reg, sq_res_reg, sq_bit_reg;
    logic [4:0]         sq_cnt_reg;
    logic [30:0]        len_reg;

    logic [CW-1:0]      idx_reg;
    logic signed [31:0] prev_x_reg, prev_y_reg, cur_x_reg, cur_y_reg;
    logic [30:0]        prev_cum_reg;
    logic signed [33:0] local_reg;
    logic [64:0]        dvd_x_reg, dvd_y_reg;
    logic [30:0]        rem_x_reg, rem_y_reg;
    logic               neg_x_reg, neg_y_reg;
    logic [6:0]         div_cnt_reg;

    logic               done_reg, beyond_reg;
    logic signed [31:0] rx_reg, ry_reg;
    logic [1:0]         status_reg;

    // Memory port
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [EW-1:0] ram_wdata, ram_rdata;
    entry_t        wr_entry, rd_entry;

    // Shared multiplier
    logic [32:0] mul_a, mul_b;
    logic [65:0] mul_p;

    logic               accept;
    logic               few_query;
    logic signed [32:0] dxa, dya, dxs, dys;
    logic [32:0]        abs_dxa, abs_dya, abs_dxs, abs_dys, abs_local;
    logic [65:0]        sq_sum;
    logic [62:0]        sq_try;
    logic [31:0]        cum_sum;
    logic [30:0]        cum_sat;
    logic signed [33:0] local_calc;
    logic [31:0]        cand_x, cand_y;
    logic               ge_x, ge_y;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign few_query = accept && operation == OP_QUERY && count_reg < CW'(2);

    // Differences and magnitudes
    assign dxa     = {point_x[31], point_x} - {last_x_reg[31], last_x_reg};
    assign dya     = {point_y[31], point_y} - {last_y_reg[31], last_y_reg};
    assign abs_dxa = dxa[32] ? 33'(-dxa) : 33'(dxa);
    assign abs_dya = dya[32] ? 33'(-dya) : 33'(dya);
    assign dxs     = {cur_x_reg[31], cur_x_reg} - {prev_x_reg[31], prev_x_reg};
    assign dys     = {cur_y_reg[31], cur_y_reg} - {prev_y_reg[31], prev_y_reg};
    assign abs_dxs = dxs[32] ? 33'(-dxs) : 33'(dxs);
    assign abs_dys = dys[32] ? 33'(-dys) : 33'(dys);
    assign abs_local = local_reg[33] ? 33'(-local_reg) : 33'(local_reg);

    // Select multiplier operands
    always_comb
    begin
        case (state_reg)
            S_SQX:   begin mul_a = ax_reg;  mul_b = ax_reg;    end
            S_SQY:   begin mul_a = ay_reg;  mul_b = ay_reg;    end
            S_MULX:  begin mul_a = abs_dxs; mul_b = abs_local; end
            S_MULY:  begin mul_a = abs_dys; mul_b = abs_local; end
            default: begin mul_a = '0;      mul_b = '0;        end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign sq_sum  = sx_reg + mul_p;
    assign sq_try  = sq_res_reg + sq_bit_reg;
    assign cum_sum = {1'b0, last_cum_reg} + {1'b0, len_reg};
    assign cum_sat = cum_sum[31] ? LEN_MAX : cum_sum[30:0];
    assign local_calc = {{2{pos_reg[31]}}, pos_reg} - {3'b000, prev_cum_reg};

    // Divider steps, one quotient bit per cycle
    assign cand_x = {rem_x_reg, dvd_x_reg[64]};
    assign cand_y = {rem_y_reg, dvd_y_reg[64]};
    assign ge_x   = cand_x >= {1'b0, len_reg};
    assign ge_y   = cand_y >= {1'b0, len_reg};

    // Memory write data and address
    always_comb
    begin
        wr_entry = '{x: point_x, y: point_y, cum: '0, len: '0};
        ram_we   = 1'b0;
        if (state_reg == S_WRITE)
        begin
            wr_entry = '{x: px_reg, y: py_reg, cum: cum_sat, len: len_reg};
            ram_we   = 1'b1;
        end
        else if (accept && operation == OP_APPEND && count_reg == '0)
        begin
            ram_we = 1'b1;
        end
    end
    assign ram_wdata = wr_entry;
    assign ram_addr  = ram_we ? count_reg[AW-1:0] : idx_reg[AW-1:0];
    assign rd_entry  = entry_t'(ram_rdata);

    ppal_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Clamp quotient, apply sign and saturate to 32 bits
    function automatic logic signed [31:0] lerp_out(input logic signed [31:0] a,
                                                    input logic [64:0] q,
                                                    input logic neg);
        logic [40:0]        qc;
        logic signed [42:0] r;
        qc = (q > 65'h100_0000_0000) ? 41'h100_0000_0000 : q[40:0];
        r  = neg ? ({{11{a[31]}}, a} - {2'b00, qc}) : ({{11{a[31]}}, a} + {2'b00, qc});
        if (r > 43'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (r < -43'sd2147483648)
            return 32'sh8000_0000;
        else
            return r[31:0];
    endfunction

    // Sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            beyond_reg <= 1'b0;
            status_reg <= ST_OK;
            rx_reg     <= '0;
            ry_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        rx_reg     <= '0;
                        ry_reg     <= '0;
                        beyond_reg <= 1'b0;
                        status_reg <= ST_OK;
                        px_reg     <= point_x;
                        py_reg     <= point_y;
                        pos_reg    <= query_length;
                        ax_reg     <= abs_dxa;
                        ay_reg     <= abs_dya;
                        idx_reg    <= '0;
                        case (operation)
                            OP_CLEAR:
                            begin
                                count_reg <= '0;
                                done_reg  <= 1'b1;
                            end
                            OP_APPEND:
                            begin
                                if (count_reg >= CW'(MAX_POINTS))
                                begin
                                    status_reg <= ST_FULL;
                                    done_reg   <= 1'b1;
                                end
                                else if (count_reg == '0)
                                begin
                                    last_x_reg   <= point_x;
                                    last_y_reg   <= point_y;
                                    last_cum_reg <= '0;
                                    count_reg    <= CW'(1);
                                    done_reg     <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_SQX;
                                end
                            end
                            OP_QUERY:
                            begin
                                if (count_reg < CW'(2))
                                begin
                                    status_reg <= ST_FEW;
                                    done_reg   <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_RD;
                                end
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_SQX:
                begin
                    sx_reg    <= mul_p;
                    state_reg <= S_SQY;
                end
                S_SQY:
                begin
                    // Saturate when either square or the sum reaches 2^62
                    if (sq_sum[65:62] != 4'd0)
                    begin
                        len_reg   <= LEN_MAX;
                        state_reg <= S_WRITE;
                    end
                    else
                    begin
                        sq_n_reg   <= {1'b0, sq_sum[61:0]};
                        sq_res_reg <= '0;
                        sq_bit_reg <= 63'h1000_0000_0000_0000;
                        sq_cnt_reg <= 5'd30;
                        state_reg  <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (sq_n_reg >= sq_try)
                    begin
                        sq_n_reg   <= sq_n_reg - sq_try;
                        sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                    end
                    else
                    begin
                        sq_res_reg <= sq_res_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                    sq_cnt_reg <= sq_cnt_reg - 5'd1;
                    if (sq_cnt_reg == '0)
                    begin
                        len_reg   <= (sq_n_reg >= sq_try) ?
                                     31'((sq_res_reg >> 1) + sq_bit_reg) :
                                     31'(sq_res_reg >> 1);
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    last_x_reg   <= px_reg;
                    last_y_reg   <= py_reg;
                    last_cum_reg <= cum_sat;
                    count_reg    <= count_reg + CW'(1);
                    done_reg     <= 1'b1;
                    state_reg    <= S_IDLE;
                end
                S_RD:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (idx_reg != '0 && $signed({1'b0, rd_entry.cum}) > pos_reg)
                    begin
                        cur_x_reg <= rd_entry.x;
                        cur_y_reg <= rd_entry.y;
                        len_reg   <= rd_entry.len;
                        local_reg <= local_calc;
                        if (rd_entry.len == '0)
                        begin
                            rx_reg    <= prev_x_reg;
                            ry_reg    <= prev_y_reg;
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_MULX;
                        end
                    end
                    else
                    begin
                        prev_x_reg   <= rd_entry.x;
                        prev_y_reg   <= rd_entry.y;
                        prev_cum_reg <= rd_entry.cum;
                        if (idx_reg + CW'(1) == count_reg)
                        begin
                            // No segment end passes the length: return the last point
                            rx_reg     <= last_x_reg;
                            ry_reg     <= last_y_reg;
                            beyond_reg <= 1'b1;
                            done_reg   <= 1'b1;
                            state_reg  <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + CW'(1);
                            state_reg <= S_RD;
                        end
                    end
                end
                S_MULX:
                begin
                    dvd_x_reg <= mul_p[64:0];
                    neg_x_reg <= dxs[32] ^ local_reg[33];
                    rem_x_reg <= '0;
                    state_reg <= S_MULY;
                end
                S_MULY:
                begin
                    dvd_y_reg   <= mul_p[64:0];
                    neg_y_reg   <= dys[32] ^ local_reg[33];
                    rem_y_reg   <= '0;
                    div_cnt_reg <= 7'd64;
                    state_reg   <= S_DIV;
                end
                S_DIV:
                begin
                    rem_x_reg   <= ge_x ? 31'(cand_x - {1'b0, len_reg}) : cand_x[30:0];
                    rem_y_reg   <= ge_y ? 31'(cand_y - {1'b0, len_reg}) : cand_y[30:0];
                    dvd_x_reg   <= {dvd_x_reg[63:0], ge_x};
                    dvd_y_reg   <= {dvd_y_reg[63:0], ge_y};
                    div_cnt_reg <= div_cnt_reg - 7'd1;
                    if (div_cnt_reg == '0)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    rx_reg    <= lerp_out(prev_x_reg, dvd_x_reg, neg_x_reg);
                    ry_reg    <= lerp_out(prev_y_reg, dvd_y_reg, neg_y_reg);
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done       = done_reg;
    assign result_x   = rx_reg;
    assign result_y   = ry_reg;
    assign beyond_end = beyond_reg;
    assign status     = status_reg;

    `PPAL_ASSERT(a_done_idle, done_reg |-> (state_reg == S_IDLE), "result while busy")
    `PPAL_NEVER(a_count_max, count_reg > CW'(MAX_POINTS), "point count above capacity")
    `PPAL_ASSERT(a_write_room, ram_we |-> (count_reg < CW'(MAX_POINTS)), "write past capacity")
    `PPAL_ASSERT(a_few_query, few_query |=> (done_reg && status_reg == ST_FEW), "not flagged")
    `PPAL_ASSERT(a_beyond_ok, (done_reg && beyond_reg) |-> (status_reg == ST_OK), "beyond, bad status")

endmodule
